// ----- rtl/mi3_pkg.sv -----
// Shared constants and index tables for the 3x3 matrix inverse pipeline.
`default_nettype none
package mi3_pkg;

  localparam int unsigned N_ELEM = 9;
  localparam int unsigned N_ROW  = 3;

  typedef logic [3:0] idx_t;

  // Cofactor i is m[COF_A[i]]*m[COF_B[i]] - m[COF_C[i]]*m[COF_D[i]], already transposed.
  localparam idx_t COF_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t COF_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t COF_C [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_t COF_D [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // Adjugate entries that multiply the first row in the determinant expansion.
  localparam idx_t DET_COL [N_ROW] = '{4'd0, 4'd3, 4'd6};

endpackage
`default_nettype wire

// ----- rtl/matrix3_inverse.sv -----
// Top level of the pipelined 3x3 matrix inverse.
`default_nettype none
// Takes one 3x3 signed fixed-point matrix per cycle while in_stall is low and returns
// its inverse, rounded to nearest and saturated, with singular and saturated flags.
// The stages are an input register, the cofactor products, the determinant, then one
// long-division stage per quotient bit plus an overflow stage (ELEM_WIDTH+2 of them,
// nine lanes) and a rounding stage into the output register. A two-entry output buffer
// keeps the pipeline moving for one more transfer after the output stalls; once it is
// full the whole pipeline holds and in_stall rises.
module matrix3_inverse #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0_c0,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0_c1,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r0_c2,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1_c0,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1_c1,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r1_c2,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2_c0,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2_c1,
  input  wire logic signed [ELEM_WIDTH-1:0] in_r2_c2,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [ELEM_WIDTH-1:0]      out_r0_c0,
  output logic signed [ELEM_WIDTH-1:0]      out_r0_c1,
  output logic signed [ELEM_WIDTH-1:0]      out_r0_c2,
  output logic signed [ELEM_WIDTH-1:0]      out_r1_c0,
  output logic signed [ELEM_WIDTH-1:0]      out_r1_c1,
  output logic signed [ELEM_WIDTH-1:0]      out_r1_c2,
  output logic signed [ELEM_WIDTH-1:0]      out_r2_c0,
  output logic signed [ELEM_WIDTH-1:0]      out_r2_c1,
  output logic signed [ELEM_WIDTH-1:0]      out_r2_c2,
  output logic                              singular,
  output logic                              saturated
);

  localparam int unsigned E     = ELEM_WIDTH;
  localparam int unsigned NE    = mi3_pkg::N_ELEM;
  localparam int unsigned AW    = 2*E + 1;
  localparam int unsigned DW    = 3*E + 3;
  localparam int unsigned NW    = AW + 2*FRAC_BITS;
  localparam int unsigned QW    = E + 1;
  localparam int unsigned DSPAN = DW + QW + 1;
  localparam int unsigned W     = (NW > DSPAN) ? NW : DSPAN;
  localparam int unsigned NDIV  = QW + 1;
  localparam int unsigned NP    = 7 + NDIV;
  localparam int unsigned RW    = NE*E + 2;

  logic          en;
  logic [NP-1:0] v;
  logic          exit_ok;

  logic signed [E-1:0] m    [NE];
  logic signed [AW-1:0] adj [NE];
  logic signed [E-1:0] row0 [mi3_pkg::N_ROW];
  logic [AW-1:0]       amag [NE];
  logic [NE-1:0]       neg;
  logic [DW-1:0]       dmag;
  logic                zero;

  logic [W-1:0]  rem_init [NE];
  logic [W-1:0]  rem_q    [NDIV][NE];
  logic [QW-1:0] q_q      [NDIV][NE];
  logic          over_q   [NDIV][NE];
  logic [DW-1:0] d_p      [NDIV];
  logic [NE-1:0] neg_p    [NDIV];
  logic          zero_p   [NDIV];

  logic [E-1:0]  rval [NE];
  logic [NE-1:0] rsat;
  logic [RW-1:0] item;
  logic [RW-1:0] out_data;
  logic [RW-1:0] skid_data;
  logic          skid_v;

  // The pipeline advances as one until the output buffer is full.
  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign exit_ok  = en && v[NP-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NP-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= in_r0_c0;
      m[1] <= in_r0_c1;
      m[2] <= in_r0_c2;
      m[3] <= in_r1_c0;
      m[4] <= in_r1_c1;
      m[5] <= in_r1_c2;
      m[6] <= in_r2_c0;
      m[7] <= in_r2_c1;
      m[8] <= in_r2_c2;
    end
  end

  mi3_cofactor #(.E(E)) u_cofactor (
    .clk  (clk),
    .en   (en),
    .m    (m),
    .adj  (adj),
    .row0 (row0)
  );

  mi3_det #(.E(E)) u_det (
    .clk  (clk),
    .en   (en),
    .adj  (adj),
    .row0 (row0),
    .amag (amag),
    .neg  (neg),
    .dmag (dmag),
    .zero (zero)
  );

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      rem_init[i] = W'(amag[i]) << (2*FRAC_BITS);
    end
  end

  genvar gs, gl;
  generate
    for (gs = 0; gs < NDIV; gs++) begin : g_div
      logic [DW-1:0] d_in;
      logic [NE-1:0] neg_in;
      logic          zero_in;
      if (gs == 0) begin : g_first
        assign d_in    = dmag;
        assign neg_in  = neg;
        assign zero_in = zero;
      end else begin : g_rest
        assign d_in    = d_p[gs-1];
        assign neg_in  = neg_p[gs-1];
        assign zero_in = zero_p[gs-1];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          d_p[gs]    <= d_in;
          neg_p[gs]  <= neg_in;
          zero_p[gs] <= zero_in;
        end
      end

      for (gl = 0; gl < NE; gl++) begin : g_lane
        logic [W-1:0]  rem_in;
        logic [QW-1:0] q_in;
        logic          over_in;
        if (gs == 0) begin : g_first
          assign rem_in  = rem_init[gl];
          assign q_in    = '0;
          assign over_in = 1'b0;
        end else begin : g_rest
          assign rem_in  = rem_q[gs-1][gl];
          assign q_in    = q_q[gs-1][gl];
          assign over_in = over_q[gs-1][gl];
        end

        mi3_div_step #(.W(W), .DW(DW), .QW(QW), .K(QW - gs)) u_step (
          .clk     (clk),
          .en      (en),
          .d       (d_in),
          .rem_in  (rem_in),
          .q_in    (q_in),
          .over_in (over_in),
          .rem     (rem_q[gs][gl]),
          .q       (q_q[gs][gl]),
          .over    (over_q[gs][gl])
        );
      end
    end

    for (gl = 0; gl < NE; gl++) begin : g_round
      mi3_round #(.E(E), .W(W), .DW(DW)) u_round (
        .rem  (rem_q[NDIV-1][gl]),
        .q    (q_q[NDIV-1][gl]),
        .over (over_q[NDIV-1][gl]),
        .neg  (neg_p[NDIV-1][gl]),
        .d    (d_p[NDIV-1]),
        .val  (rval[gl]),
        .sat  (rsat[gl])
      );
    end
  endgenerate

  // A singular matrix gives all zeros and never counts as saturated.
  always_comb begin
    for (int i = 0; i < NE; i++) begin
      item[i*E +: E] = zero_p[NDIV-1] ? '0 : rval[i];
    end
    item[NE*E]     = zero_p[NDIV-1];
    item[NE*E + 1] = !zero_p[NDIV-1] && (|rsat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (exit_ok) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_valid <= 1'b1;
      skid_v    <= 1'b0;
    end else begin
      out_valid <= exit_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (exit_ok) begin
        skid_data <= item;
      end
    end else if (skid_v) begin
      out_data <= skid_data;
    end else if (exit_ok) begin
      out_data <= item;
    end
  end

  assign out_r0_c0 = out_data[0*E +: E];
  assign out_r0_c1 = out_data[1*E +: E];
  assign out_r0_c2 = out_data[2*E +: E];
  assign out_r1_c0 = out_data[3*E +: E];
  assign out_r1_c1 = out_data[4*E +: E];
  assign out_r1_c2 = out_data[5*E +: E];
  assign out_r2_c0 = out_data[6*E +: E];
  assign out_r2_c1 = out_data[7*E +: E];
  assign out_r2_c2 = out_data[8*E +: E];
  assign singular  = out_data[NE*E];
  assign saturated = out_data[NE*E + 1];

`ifndef SYNTHESIS
  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("buffered result without a result on the output");

  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && out_stall))
    else $error("output buffer filled while the output was free");

  a_hold_pipe : assert property (@(posedge clk) disable iff (rst)
    skid_v |=> v == $past(v))
    else $error("pipeline moved while the output buffer was full");

  a_singular_clean : assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> !saturated && out_r0_c0 == '0 && out_r2_c2 == '0)
    else $error("singular result carries data or saturation");
`endif

endmodule
`default_nettype wire

// ----- rtl/mi3_cofactor.sv -----
// Two-stage cofactor unit: eighteen products, then the nine adjugate entries.
`default_nettype none
module mi3_cofactor #(
  parameter int unsigned E = 32
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [E-1:0] m    [mi3_pkg::N_ELEM],
  output logic signed [2*E:0]      adj  [mi3_pkg::N_ELEM],
  output logic signed [E-1:0]      row0 [mi3_pkg::N_ROW]
);

  logic signed [2*E-1:0] pa      [mi3_pkg::N_ELEM];
  logic signed [2*E-1:0] pb      [mi3_pkg::N_ELEM];
  logic signed [E-1:0]   row0_s1 [mi3_pkg::N_ROW];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
        pa[i]  <= m[mi3_pkg::COF_A[i]] * m[mi3_pkg::COF_B[i]];
        pb[i]  <= m[mi3_pkg::COF_C[i]] * m[mi3_pkg::COF_D[i]];
        adj[i] <= (2*E+1)'(pa[i]) - (2*E+1)'(pb[i]);
      end
      for (int i = 0; i < mi3_pkg::N_ROW; i++) begin
        row0_s1[i] <= m[i];
        row0[i]    <= row0_s1[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mi3_det.sv -----
// Determinant pipeline: split products, terms, sum, then magnitudes and signs.
`default_nettype none
module mi3_det #(
  parameter int unsigned E = 32
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [2*E:0] adj  [mi3_pkg::N_ELEM],
  input  wire logic signed [E-1:0] row0 [mi3_pkg::N_ROW],
  output logic [2*E:0]             amag [mi3_pkg::N_ELEM],
  output logic [mi3_pkg::N_ELEM-1:0] neg,
  output logic [3*E+2:0]           dmag,
  output logic                     zero
);

  localparam int unsigned AW = 2*E + 1;
  localparam int unsigned DW = 3*E + 3;

  logic signed [AW-1:0] plo    [mi3_pkg::N_ROW];
  logic signed [AW-1:0] phi    [mi3_pkg::N_ROW];
  logic signed [DW-1:0] term   [mi3_pkg::N_ROW];
  logic signed [DW-1:0] det;
  logic signed [AW-1:0] adj_s3 [mi3_pkg::N_ELEM];
  logic signed [AW-1:0] adj_s4 [mi3_pkg::N_ELEM];
  logic signed [AW-1:0] adj_s5 [mi3_pkg::N_ELEM];

  // The wide adjugate entry is cut into an unsigned low half and a signed high half.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::N_ROW; i++) begin
        plo[i]  <= row0[i] * $signed({1'b0, adj[mi3_pkg::DET_COL[i]][E-1:0]});
        phi[i]  <= row0[i] * $signed(adj[mi3_pkg::DET_COL[i]][AW-1:E]);
        term[i] <= (DW'(phi[i]) <<< E) + DW'(plo[i]);
      end
      det  <= term[0] + term[1] + term[2];
      zero <= (det == '0);
      dmag <= det[DW-1] ? DW'(-det) : DW'(det);
      for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
        adj_s3[i] <= adj[i];
        adj_s4[i] <= adj_s3[i];
        adj_s5[i] <= adj_s4[i];
        neg[i]    <= adj_s5[i][AW-1] ^ det[DW-1];
        amag[i]   <= adj_s5[i][AW-1] ? AW'(-adj_s5[i]) : AW'(adj_s5[i]);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mi3_div_step.sv -----
// One restoring divide step per lane: compare, subtract, set quotient or overflow.
`default_nettype none
module mi3_div_step #(
  parameter int unsigned W  = 134,
  parameter int unsigned DW = 99,
  parameter int unsigned QW = 33,
  parameter int unsigned K  = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] d,
  input  wire logic [W-1:0]  rem_in,
  input  wire logic [QW-1:0] q_in,
  input  wire logic          over_in,
  output logic [W-1:0]       rem,
  output logic [QW-1:0]      q,
  output logic               over
);

  logic [W-1:0] dsh;
  logic         ge;

  assign dsh = W'(d) << K;
  assign ge  = (rem_in >= dsh);

  // The top step weighs beyond the quotient field, so a hit there means overflow.
  generate
    if (K == QW) begin : g_over
      always_ff @(posedge clk) begin
        if (en) begin
          rem  <= ge ? rem_in - dsh : rem_in;
          q    <= q_in;
          over <= over_in | ge;
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (en) begin
          rem  <= ge ? rem_in - dsh : rem_in;
          q    <= q_in | (QW'(ge) << K);
          over <= over_in;
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

// ----- rtl/mi3_round.sv -----
// Rounding to nearest, saturation and sign for one quotient lane.
`default_nettype none
module mi3_round #(
  parameter int unsigned E  = 32,
  parameter int unsigned W  = 134,
  parameter int unsigned DW = 99
) (
  input  wire logic [W-1:0]  rem,
  input  wire logic [E:0]    q,
  input  wire logic          over,
  input  wire logic          neg,
  input  wire logic [DW-1:0] d,
  output logic [E-1:0]       val,
  output logic               sat
);

  logic [W:0]   rem2;
  logic         rnd;
  logic [E+1:0] qf;
  logic [E+1:0] lim;
  logic [E+1:0] mag;
  logic [E+1:0] smag;

  always_comb begin
    rem2 = {rem, 1'b0};
    rnd  = (rem2 >= (W+1)'(d));
    qf   = (E+2)'(q) + (E+2)'(rnd);
    // A negative result may reach one step further than a positive one.
    lim  = ((E+2)'(1) << (E-1)) - (neg ? '0 : (E+2)'(1));
    sat  = over || (qf > lim);
    mag  = sat ? lim : qf;
    smag = neg ? (E+2)'(-mag) : mag;
    val  = smag[E-1:0];
  end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
`default_nettype none
module tb;

  localparam int EW = 32;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef logic [8:0][EW-1:0] mat_t;
  typedef struct packed {
    mat_t e;
    logic sing;
    logic sat;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  mat_t mat_in = '0;
  logic signed [EW-1:0] out_e [9];
  logic singular, saturated;

  inverse_t expected_inverses[$];
  int mismatches = 0;
  int inverses_checked = 0;
  int singular_seen = 0;
  int saturated_seen = 0;
  int idle_cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit running = 1'b1;

  matrix3_inverse #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_r0_c0(mat_in[0]), .in_r0_c1(mat_in[1]), .in_r0_c2(mat_in[2]),
    .in_r1_c0(mat_in[3]), .in_r1_c1(mat_in[4]), .in_r1_c2(mat_in[5]),
    .in_r2_c0(mat_in[6]), .in_r2_c1(mat_in[7]), .in_r2_c2(mat_in[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r0_c0(out_e[0]), .out_r0_c1(out_e[1]), .out_r0_c2(out_e[2]),
    .out_r1_c0(out_e[3]), .out_r1_c1(out_e[4]), .out_r1_c2(out_e[5]),
    .out_r2_c0(out_e[6]), .out_r2_c1(out_e[7]), .out_r2_c2(out_e[8]),
    .singular(singular), .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact adjugate and determinant in wide signed arithmetic, then a rounded,
  // saturated quotient for each element.
  function automatic inverse_t invert_matrix(input mat_t m);
    logic signed [191:0] w [9];
    logic signed [191:0] adj [9];
    logic signed [191:0] det;
    logic [191:0] num, den, quo, rem, lim;
    logic neg;
    inverse_t res;
    res = '0;
    for (int i = 0; i < 9; i++) w[i] = {{(192-EW){m[i][EW-1]}}, m[i]};
    adj[0] = w[4]*w[8] - w[5]*w[7];
    adj[1] = w[2]*w[7] - w[1]*w[8];
    adj[2] = w[1]*w[5] - w[2]*w[4];
    adj[3] = w[5]*w[6] - w[3]*w[8];
    adj[4] = w[0]*w[8] - w[2]*w[6];
    adj[5] = w[2]*w[3] - w[0]*w[5];
    adj[6] = w[3]*w[7] - w[4]*w[6];
    adj[7] = w[1]*w[6] - w[0]*w[7];
    adj[8] = w[0]*w[4] - w[1]*w[3];
    det = w[0]*adj[0] + w[1]*adj[3] + w[2]*adj[6];
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    den = det[191] ? -det : det;
    for (int i = 0; i < 9; i++) begin
      neg = adj[i][191] ^ det[191];
      num = adj[i][191] ? -adj[i] : adj[i];
      num = num << (2*FB);
      quo = num / den;
      rem = num % den;
      if ((rem << 1) >= den) quo = quo + 1;
      lim = neg ? (192'd1 << (EW-1)) : ((192'd1 << (EW-1)) - 1);
      if (quo > lim) begin
        quo = lim;
        res.sat = 1'b1;
      end
      res.e[i] = neg ? EW'(-quo) : EW'(quo);
    end
    return res;
  endfunction

  // Sends one matrix; valid stays high afterwards so back-to-back transfers are possible.
  task automatic send_matrix(input mat_t m);
    if (send_gaps && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mat_in <= m;
    do @(posedge clk); while (in_stall);
    expected_inverses.push_back(invert_matrix(m));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_inverses.size() != 0) @(negedge clk);
  endtask

  function automatic logic [EW-1:0] q16(input int v);
    return EW'(v) << FB;
  endfunction

  function automatic mat_t diag(input logic [EW-1:0] a, b, c);
    mat_t m;
    m = '0;
    m[0] = a;
    m[4] = b;
    m[8] = c;
    return m;
  endfunction

  function automatic logic [EW-1:0] rand_elem(input int shape);
    case (shape)
      0: return $urandom();
      1: return EW'($urandom_range(0, 1 << 19)) - EW'(1 << 18);
      2: return q16($urandom_range(0, 16) - 8);
      default: return EW'($urandom_range(0, 64)) - EW'(32);
    endcase
  endfunction

  task automatic test_directed();
    mat_t m;
    send_matrix(diag(q16(1), q16(1), q16(1)));
    send_matrix('0);
    send_matrix(diag(q16(2), q16(-4), q16(8)));
    send_matrix(diag(q16(3), q16(3), q16(-3)));
    send_matrix(diag(32'd1, 32'd1, 32'd1));
    send_matrix(diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_matrix(diag(32'h80000000, 32'h80000000, 32'h80000000));
    send_matrix(diag(32'h80000000, 32'h7fffffff, 32'hffffffff));
    send_matrix({9{32'h7fffffff}});
    send_matrix({9{32'h80000000}});
    send_matrix({9{32'hffffffff}});
    // Permutation matrix with a negative determinant.
    m = '0;
    m[1] = q16(1);
    m[3] = q16(1);
    m[8] = q16(1);
    send_matrix(m);
    // Rank-deficient: the third row is the sum of the first two.
    for (int i = 0; i < 3; i++) begin
      m[i] = q16(i + 1);
      m[3+i] = q16(2 - i);
      m[6+i] = m[i] + m[3+i];
    end
    send_matrix(m);
    // A determinant of 2^33 puts two results exactly halfway between two steps,
    // which tests round-half-away.
    m = '0;
    m[0] = 32'h00020000;
    m[1] = 32'h00020000;
    m[3] = 32'hffff0001;
    m[4] = 32'h00000001;
    m[8] = 32'h00000001;
    send_matrix(m);
    send_matrix(diag(q16(1) <<< 1, q16(1), 32'h00020000));
    send_matrix(diag(32'h00000002, q16(1), q16(1)));
    send_matrix(diag(32'h00018000, q16(-1), 32'h00008000));
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'h55555555 : 32'haaaaaaaa;
    send_matrix(m);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    mat_t m;
    int shape;
    for (int n = 0; n < count; n++) begin
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) m[i] = rand_elem(shape < 2 ? 0 : shape < 6 ? 1 : shape - 6);
      // Mostly diagonally dominant so the inverse lands inside the format.
      if (shape >= 2 && shape < 8)
        for (int i = 0; i < 3; i++) m[4*i] = m[4*i] + q16($urandom_range(0, 1) ? 6 : -6);
      if (shape == 9) m[6 + $urandom_range(0, 2)] = m[$urandom_range(0, 2)];
      send_matrix(m);
    end
  endtask

  task automatic test_drain_pause();
    test_random(40);
    wait_drained();
    test_random(40);
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(150);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  always @(negedge clk) begin
    out_stall <= !rst && recv_gaps && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    inverse_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = expected_inverses.pop_front();
        inverses_checked++;
        singular_seen += singular;
        saturated_seen += saturated;
        for (int i = 0; i < 11; i++) begin
          logic [EW-1:0] exp_v, got_v;
          exp_v = i < 9 ? want.e[i] : (i == 9 ? EW'(want.sing) : EW'(want.sat));
          got_v = i < 9 ? out_e[i] : (i == 9 ? EW'(singular) : EW'(saturated));
          if (got_v !== exp_v) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d mismatch: expected %h, got %h", i, exp_v, got_v);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || !running)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(200);
    test_drain_pause();
    test_full_rate();
    test_random(150);
    wait_drained();
    running = 1'b0;
    repeat (60) @(negedge clk);
    if (expected_inverses.size() != 0) mismatches++;
    $display("Checked %0d inverses: %0d singular, %0d saturated.",
             inverses_checked, singular_seen, saturated_seen);
    $display("Stimulus mixed directed extremes, random and near-singular matrices.");
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
